/* rtl/core/yuvrgb_pkg.sv */
`default_nettype none

package yuvrgb_pkg;

  localparam int unsigned LumaW   = 17;  // 298 * 239 fits in 17 bits
  localparam int unsigned ChromaW = 18;  // signed chroma terms, blue is widest
  localparam int unsigned SumW    = 19;  // luma + chroma, signed
  localparam int unsigned ColW    = SumW - 8;

  localparam logic [7:0]  LumaBlack  = 8'd16;
  localparam logic [8:0]  LumaGain   = 9'd298;
  localparam logic [8:0]  ChromaZero = 9'd128;

  localparam logic signed [ChromaW-1:0] CrToRed   = 18'sd409;
  localparam logic signed [ChromaW-1:0] CbToGreen = -18'sd100;
  localparam logic signed [ChromaW-1:0] CrToGreen = -18'sd208;
  localparam logic signed [ChromaW-1:0] CbToBlue  = 18'sd516;
  localparam logic signed [ChromaW-1:0] RoundHalf = 18'sd128;

  localparam logic signed [ColW-1:0] ColourMax = 11'sd255;

  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } yuvrgb_in_t;

  typedef struct packed {
    logic [15:0] pixel_top_left;
    logic [15:0] pixel_top_right;
    logic [15:0] pixel_bottom_left;
    logic [15:0] pixel_bottom_right;
  } yuvrgb_out_t;

  function automatic logic [7:0] clip_colour(input logic signed [ColW-1:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > ColourMax) begin
      res = 8'hFF;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/yuv420_block_to_rgb565_core.sv */
`default_nettype none
// 2x2 I420 block to four RGB565 pixels, BT.601 limited range.
// Input channel: in_valid_i / in_stall_o with one block (four Y, shared Cb/Cr)
// in in_data_i; an item is taken on a clock edge with valid high, stall low.
// Output channel: out_valid_o / out_stall_i, four pixels in out_data_o.
// Throughput: one block per cycle while out_stall_i is low. Latency: three
// register stages (stage 1 constant multiplies, stage 2 sums and shift,
// stage 3 clip, pack and byte swap into the output register).
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles are squeezed out under a stall; in_stall_o
// rises only once all three stages hold an item and the output is stalled.
// A stalled output holds its item unchanged.
// cfg_we_i/cfg_wdata_i write the byte-swap bit (swaps the bytes of each
// pixel); write it only while the pipeline is empty.
// Reset clears all valid bits and the byte-swap bit.
module yuv420_block_to_rgb565_core (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire yuvrgb_pkg::yuvrgb_in_t  in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output yuvrgb_pkg::yuvrgb_out_t      out_data_o,
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_wdata_i
);
  import yuvrgb_pkg::*;

  logic swap_q;

  // stage valid bits and per-stage advance
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  assign adv3 = !v3_q || !out_stall_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_stall_o = !adv1;

  // stage 1: luma and chroma products
  logic [7:0]              luma_in [4];
  logic [LumaW-1:0]        lterm_d [4];
  logic [LumaW-1:0]        lterm_q [4];
  logic signed [ChromaW-1:0] red_d, green_d, blue_d;
  logic signed [ChromaW-1:0] red_q, green_q, blue_q;
  logic signed [ChromaW-1:0] cb_s, cr_s;

  assign luma_in[0] = in_data_i.luma_top_left;
  assign luma_in[1] = in_data_i.luma_top_right;
  assign luma_in[2] = in_data_i.luma_bottom_left;
  assign luma_in[3] = in_data_i.luma_bottom_right;

  always_comb begin
    cb_s = $signed({10'd0, in_data_i.chroma_blue}) - $signed({9'd0, ChromaZero});
    cr_s = $signed({10'd0, in_data_i.chroma_red}) - $signed({9'd0, ChromaZero});
    red_d   = CrToRed * cr_s + RoundHalf;
    green_d = CbToGreen * cb_s + CrToGreen * cr_s + RoundHalf;
    blue_d  = CbToBlue * cb_s + RoundHalf;
  end

  for (genvar k = 0; k < 4; k++) begin : g_luma
    logic [7:0] yl;
    // Y below black counts as black
    assign yl = (luma_in[k] > LumaBlack) ? (luma_in[k] - LumaBlack) : 8'd0;
    assign lterm_d[k] = {{(LumaW-8){1'b0}}, yl} * {{(LumaW-9){1'b0}}, LumaGain};
  end

  // stage 2: sums, floor shift by 8
  logic signed [ColW-1:0] r_d [4], g_d [4], b_d [4];
  logic signed [ColW-1:0] r_q [4], g_q [4], b_q [4];

  for (genvar k = 0; k < 4; k++) begin : g_sum
    logic signed [SumW-1:0] lt, rs, gs, bs;
    assign lt = $signed({{(SumW-LumaW){1'b0}}, lterm_q[k]});
    assign rs = lt + $signed({{(SumW-ChromaW){red_q[ChromaW-1]}}, red_q});
    assign gs = lt + $signed({{(SumW-ChromaW){green_q[ChromaW-1]}}, green_q});
    assign bs = lt + $signed({{(SumW-ChromaW){blue_q[ChromaW-1]}}, blue_q});
    assign r_d[k] = rs[SumW-1:8];
    assign g_d[k] = gs[SumW-1:8];
    assign b_d[k] = bs[SumW-1:8];
  end

  // stage 3: clip, pack 5/6/5, optional byte swap
  logic [15:0] px_d [4];

  for (genvar k = 0; k < 4; k++) begin : g_pack
    logic [7:0]  rc, gc, bc;
    logic [15:0] px;
    assign rc = clip_colour(r_q[k]);
    assign gc = clip_colour(g_q[k]);
    assign bc = clip_colour(b_q[k]);
    assign px = {rc[7:3], gc[7:2], bc[7:3]};
    assign px_d[k] = swap_q ? {px[7:0], px[15:8]} : px;
  end

  yuvrgb_out_t out_d, out_q;
  assign out_d = '{pixel_top_left:     px_d[0],
                   pixel_top_right:    px_d[1],
                   pixel_bottom_left:  px_d[2],
                   pixel_bottom_right: px_d[3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        swap_q <= cfg_wdata_i;
      end
      if (adv1) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      lterm_q <= lterm_d;
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
    if (adv2 && v1_q) begin
      r_q <= r_d;
      g_q <= g_d;
      b_q <= b_d;
    end
    if (adv3 && v2_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // input only stalls with a full pipeline
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q))
    else $error("input stalled with an empty stage");

  // a stage 2 item blocked by a stalled output stays put
  a_hold_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !adv3) |=> v2_q)
    else $error("stage 2 item lost under stall");

  // a taken output with an item behind it is refilled at once
  a_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && v2_q) |=> out_valid_o)
    else $error("bubble inserted behind a taken item");
`endif

endmodule

`default_nettype wire

/* bench/testbench.sv */
`default_nettype none

module testbench;
  import yuvrgb_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  yuvrgb_in_t  in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  yuvrgb_out_t out_data_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;

  yuvrgb_out_t pending_pixels[$];
  int          error_count = 0;
  bit          swap_setting = 1'b0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_output = 1'b0;

  // TL, TR, BL, BR luma, then Cb, Cr
  localparam yuvrgb_in_t CornerBlocks [12] = '{
    {8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},    // below black, clips low
    {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},  // clips high
    {8'd0,   8'd15,  8'd16,  8'd17,  8'd128, 8'd128},  // black threshold, neutral
    {8'd235, 8'd240, 8'd254, 8'd255, 8'd128, 8'd128},  // near white
    {8'd16,  8'd16,  8'd16,  8'd16,  8'd128, 8'd127},  // negative red sum
    {8'd17,  8'd18,  8'd16,  8'd20,  8'd129, 8'd126},  // floor on small sums
    {8'd128, 8'd128, 8'd128, 8'd128, 8'd0,   8'd255},  // saturated red
    {8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd0},    // saturated blue
    {8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55},
    {8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA},
    {8'd60,  8'd180, 8'd100, 8'd200, 8'd90,  8'd240},
    {8'd255, 8'd0,   8'd255, 8'd0,   8'd0,   8'd0}
  };

  yuv420_block_to_rgb565_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int saturate_byte(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  function automatic logic [15:0] rgb565_pixel(input logic [7:0] y, input int red_c,
                                               input int green_c, input int blue_c,
                                               input bit swap);
    int          y_above;
    int          luma_term;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [15:0] px;
    y_above = int'(y) - 16;
    luma_term = (y_above > 0) ? 298 * y_above : 0;
    // >>> on int floors toward minus infinity
    r = 8'(saturate_byte((luma_term + red_c) >>> 8));
    g = 8'(saturate_byte((luma_term + green_c) >>> 8));
    b = 8'(saturate_byte((luma_term + blue_c) >>> 8));
    px = {r[7:3], g[7:2], b[7:3]};
    return swap ? {px[7:0], px[15:8]} : px;
  endfunction

  function automatic yuvrgb_out_t convert_block(input yuvrgb_in_t blk, input bit swap);
    int          cb;
    int          cr;
    int          red_c;
    int          green_c;
    int          blue_c;
    yuvrgb_out_t px;
    cb = int'(blk.chroma_blue) - 128;
    cr = int'(blk.chroma_red) - 128;
    red_c = 409 * cr + 128;
    green_c = -100 * cb - 208 * cr + 128;
    blue_c = 516 * cb + 128;
    px.pixel_top_left     = rgb565_pixel(blk.luma_top_left, red_c, green_c, blue_c, swap);
    px.pixel_top_right    = rgb565_pixel(blk.luma_top_right, red_c, green_c, blue_c, swap);
    px.pixel_bottom_left  = rgb565_pixel(blk.luma_bottom_left, red_c, green_c, blue_c, swap);
    px.pixel_bottom_right = rgb565_pixel(blk.luma_bottom_right, red_c, green_c, blue_c, swap);
    return px;
  endfunction

  // mostly uniform, sometimes the black/white/clip edges
  function automatic logic [7:0] random_sample();
    logic [7:0] edges [8] = '{8'd0, 8'd15, 8'd16, 8'd17, 8'd235, 8'd240, 8'd254, 8'd255};
    if ($urandom_range(5) == 0) return edges[$urandom_range(7)];
    return 8'($urandom_range(255));
  endfunction

  function automatic yuvrgb_in_t random_block();
    yuvrgb_in_t blk;
    blk.luma_top_left     = random_sample();
    blk.luma_top_right    = random_sample();
    blk.luma_bottom_left  = random_sample();
    blk.luma_bottom_right = random_sample();
    blk.chroma_blue       = random_sample();
    blk.chroma_red        = random_sample();
    return blk;
  endfunction

  task automatic compare_pixel(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, field, want, got);
      error_count++;
    end
  endtask

  task automatic check_pixels(input yuvrgb_out_t got);
    yuvrgb_out_t want;
    if (pending_pixels.size() == 0) begin
      $display("%0t: unexpected item, expected none got %h", $time, got);
      error_count++;
    end else begin
      want = pending_pixels.pop_front();
      compare_pixel("pixel_top_left", want.pixel_top_left, got.pixel_top_left);
      compare_pixel("pixel_top_right", want.pixel_top_right, got.pixel_top_right);
      compare_pixel("pixel_bottom_left", want.pixel_bottom_left, got.pixel_bottom_left);
      compare_pixel("pixel_bottom_right", want.pixel_bottom_right, got.pixel_bottom_right);
    end
  endtask

  // output side: check accepted items, then pick next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_pixels(out_data_o);
    if (hold_output) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_block(input yuvrgb_in_t blk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= blk;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_pixels.push_back(convert_block(blk, swap_setting));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_byte_swap(input bit value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    swap_setting = value;
  endtask

  task automatic test_corner_blocks();
    write_byte_swap(1'b0);
    foreach (CornerBlocks[i]) send_block(CornerBlocks[i]);
    drain();
  endtask

  task automatic test_byte_swap();
    write_byte_swap(1'b1);
    foreach (CornerBlocks[i]) send_block(CornerBlocks[i]);
    drain();
  endtask

  task automatic test_random_blocks(input int idle_pct, input int stall_rate,
                                    input bit swap, input int count);
    send_idle_pct = idle_pct;
    stall_pct = stall_rate;
    write_byte_swap(swap);
    repeat (count) send_block(random_block());
    drain();
  endtask

  // receiver holds off long enough for the pipeline to fill and stall input
  task automatic test_output_hold();
    send_idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_output <= 1'b1;
        repeat (150) @(posedge clk_i);
        hold_output <= 1'b0;
      end
    join_none
    repeat (24) send_block(random_block());
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_blocks();
    test_byte_swap();
    test_random_blocks(0, 0, 1'b0, 350);
    test_random_blocks(52, 0, 1'b1, 350);
    test_random_blocks(0, 52, 1'b0, 350);
    test_random_blocks(11, 11, 1'b1, 350);
    test_output_hold();
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(8 * 300000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
